>>> design/cbps_pkg.sv
// Shared types and constants for the cubic Bezier point sampler.
// No dependencies; every other file uses this package by scoped names.
`default_nettype none

package cbps_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W         = 6;
    localparam logic [CFG_W-1:0] SAMPLES_RST = 6'd10;
    localparam int COORD_W       = 32;
    localparam int COLOR_W       = 24;
    localparam int CHAN_W        = 8;
    // power-basis coefficients: up to twelve times a coordinate, plus sign
    localparam int COEF_W        = 36;
    localparam int QDEPTH        = 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic signed [COORD_W-1:0] x3;
        logic signed [COORD_W-1:0] y3;
        logic [COLOR_W-1:0]        stroke_color;
        logic                      first_segment;
    } t_segment;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [CHAN_W-1:0]         red;
        logic [CHAN_W-1:0]         green;
        logic [CHAN_W-1:0]         blue;
        logic                      blank_jump;
        logic                      last_point;
    } t_point;

    // one segment as the back end consumes it
    typedef struct packed {
        logic signed [COORD_W-1:0] p0x;
        logic signed [COORD_W-1:0] p0y;
        logic signed [COEF_W-1:0]  d1x;
        logic signed [COEF_W-1:0]  d2x;
        logic signed [COEF_W-1:0]  d3x;
        logic signed [COEF_W-1:0]  d1y;
        logic signed [COEF_W-1:0]  d2y;
        logic signed [COEF_W-1:0]  d3y;
        logic [CHAN_W-1:0]         red;
        logic [CHAN_W-1:0]         green;
        logic [CHAN_W-1:0]         blue;
        logic                      first;
        logic [CFG_W-1:0]          n;
    } t_seg_rec;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              blank;
        logic              last;
    } t_meta;

endpackage

`default_nettype wire

>>> design/cbps_if.sv
// Valid/ready channel interfaces for segments in and points out.
// Depends on cbps_pkg for the payload types.
`default_nettype none

interface cbps_seg_if;
    logic                valid;
    logic                ready;
    cbps_pkg::t_segment  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cbps_pt_if;
    logic              valid;
    logic              ready;
    cbps_pkg::t_point  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/cbps_front.sv
// Front end: takes segment transfers and turns control points into power-basis
// coefficients. Depends on cbps_pkg and cbps_if.
`default_nettype none

module cbps_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [cbps_pkg::CFG_W-1:0]  i_samples,
    cbps_seg_if.sink                         i_seg,
    output logic                             o_valid,
    output cbps_pkg::t_seg_rec               o_rec,
    input  wire logic                        i_ready
);

    function automatic logic signed [cbps_pkg::COEF_W-1:0] times3(
        input logic signed [cbps_pkg::COEF_W-1:0] v
    );
        return (v <<< 1) + v;
    endfunction

    logic                      r_valid;
    cbps_pkg::t_seg_rec        r_rec;
    cbps_pkg::t_seg_rec        n_rec;
    logic                      take;
    logic signed [cbps_pkg::COEF_W-1:0] ax0, ax1, ax2, ax3, ay0, ay1, ay2, ay3;

    assign i_seg.ready = !r_valid || i_ready;
    assign take        = i_seg.valid && i_seg.ready;

    always_comb begin
        ax0 = cbps_pkg::COEF_W'(i_seg.payload.x0);
        ax1 = cbps_pkg::COEF_W'(i_seg.payload.x1);
        ax2 = cbps_pkg::COEF_W'(i_seg.payload.x2);
        ax3 = cbps_pkg::COEF_W'(i_seg.payload.x3);
        ay0 = cbps_pkg::COEF_W'(i_seg.payload.y0);
        ay1 = cbps_pkg::COEF_W'(i_seg.payload.y1);
        ay2 = cbps_pkg::COEF_W'(i_seg.payload.y2);
        ay3 = cbps_pkg::COEF_W'(i_seg.payload.y3);
        n_rec.p0x   = i_seg.payload.x0;
        n_rec.p0y   = i_seg.payload.y0;
        n_rec.d1x   = times3(ax1 - ax0);
        n_rec.d2x   = times3(ax0 - (ax1 <<< 1) + ax2);
        n_rec.d3x   = ax3 - ax0 + times3(ax1 - ax2);
        n_rec.d1y   = times3(ay1 - ay0);
        n_rec.d2y   = times3(ay0 - (ay1 <<< 1) + ay2);
        n_rec.d3y   = ay3 - ay0 + times3(ay1 - ay2);
        n_rec.red   = i_seg.payload.stroke_color[7:0];
        n_rec.green = i_seg.payload.stroke_color[15:8];
        n_rec.blue  = i_seg.payload.stroke_color[23:16];
        n_rec.first = i_seg.payload.first_segment;
        // zero steps behaves as one step
        n_rec.n     = (i_samples == '0) ? cbps_pkg::CFG_W'(1) : i_samples;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rec <= n_rec;
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

`default_nettype wire

>>> design/cbps_queue.sv
// Two-entry segment queue between front and back end.
// Depends on cbps_pkg.
`default_nettype none

module cbps_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  cbps_pkg::t_seg_rec      i_rec,
    output logic                    o_ready,
    output logic                    o_valid,
    output cbps_pkg::t_seg_rec      o_rec,
    input  wire logic               i_pop
);

    localparam int AW = (cbps_pkg::QDEPTH > 1) ? $clog2(cbps_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(cbps_pkg::QDEPTH + 1);

    cbps_pkg::t_seg_rec r_mem [cbps_pkg::QDEPTH];
    logic [AW-1:0]      r_wp;
    logic [AW-1:0]      r_rp;
    logic [CW-1:0]      r_cnt;
    logic               push;
    logic               pop;

    assign o_ready = r_cnt != CW'(cbps_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(cbps_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(cbps_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

endmodule

`default_nettype wire

>>> design/cbps_back.sv
// Back end: steps t over one segment and evaluates the cubic by Horner's rule
// in a three-stage multiply pipeline. Depends on cbps_pkg and cbps_if.
`default_nettype none

module cbps_back #(
    parameter int FRAC_BITS = cbps_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  cbps_pkg::t_seg_rec      i_q_rec,
    output logic                    o_q_pop,
    cbps_pt_if.source               o_pt
);

    localparam int TW   = FRAC_BITS + 1;
    localparam int MW   = TW + 1;
    localparam int H1W  = cbps_pkg::COEF_W + MW;
    localparam int H2W  = H1W + MW;
    localparam int H3W  = H2W + MW;
    localparam int NW   = cbps_pkg::CFG_W;
    localparam int NTAB = 2 ** NW;
    localparam logic [TW-1:0] ONE_T = {1'b1, {FRAC_BITS{1'b0}}};

    typedef logic [TW-1:0] t_qarr [NTAB];
    typedef logic [NW-1:0] t_rarr [NTAB];

    // long division of 2^FRAC_BITS by n: {quotient, remainder}
    function automatic logic [TW+NW-1:0] div_one(input int n);
        logic [NW:0]   rem;
        logic [NW:0]   d;
        logic [TW-1:0] q;
        d   = (n == 0) ? (NW+1)'(1) : (NW+1)'(n);
        rem = '0;
        q   = '0;
        for (int i = TW - 1; i >= 0; i--) begin
            rem = {rem[NW-1:0], (i == FRAC_BITS)};
            if (rem >= d) begin
                rem  = rem - d;
                q[i] = 1'b1;
            end
        end
        return {q, rem[NW-1:0]};
    endfunction

    function automatic t_qarr build_q();
        t_qarr tab;
        logic [TW+NW-1:0] qr;
        for (int n = 0; n < NTAB; n++) begin
            qr     = div_one(n);
            tab[n] = qr[TW+NW-1:NW];
        end
        return tab;
    endfunction

    function automatic t_rarr build_r();
        t_rarr tab;
        logic [TW+NW-1:0] qr;
        for (int n = 0; n < NTAB; n++) begin
            qr     = div_one(n);
            tab[n] = qr[NW-1:0];
        end
        return tab;
    endfunction

    localparam t_qarr QTAB = build_q();
    localparam t_rarr RTAB = build_r();

    // sequencer
    logic               r_busy;
    cbps_pkg::t_seg_rec r_seg;
    logic [NW-1:0]      r_s;
    logic [TW-1:0]      r_t;
    logic [NW-1:0]      r_r;
    logic               en;
    logic               is_last;
    logic               load;
    logic [NW:0]        rsum;
    logic               carry;
    logic [NW-1:0]      n_r;
    logic [TW-1:0]      n_t;

    // stage 1
    logic                              r_v1;
    logic signed [H1W-1:0]             r_h1x, r_h1y;
    logic signed [cbps_pkg::COEF_W-1:0] r_d1x, r_d1y;
    logic signed [cbps_pkg::COORD_W-1:0] r_p0x1, r_p0y1;
    logic [TW-1:0]                     r_t1;
    cbps_pkg::t_meta                   r_m1;
    logic signed [MW-1:0]              tm0;
    logic signed [H1W-1:0]             m1x, m1y;

    // stage 2
    logic                              r_v2;
    logic signed [H2W-1:0]             r_h2x, r_h2y;
    logic signed [cbps_pkg::COORD_W-1:0] r_p0x2, r_p0y2;
    logic [TW-1:0]                     r_t2;
    cbps_pkg::t_meta                   r_m2;
    logic signed [MW-1:0]              tm1;
    logic signed [H2W-1:0]             m2x, m2y;

    // output stage
    logic                              r_v3;
    cbps_pkg::t_point                  r_pt;
    logic signed [MW-1:0]              tm2;
    logic signed [H3W-1:0]             m3x, m3y;
    logic signed [H3W-1:0]             sum3x, sum3y;

    assign en      = !r_v3 || o_pt.ready;
    assign is_last = r_s == r_seg.n;
    assign load    = en && (!r_busy || is_last) && i_q_valid;
    assign o_q_pop = load;

    // t advances by 2^F / n with the remainder carried: t = floor(s * 2^F / n)
    always_comb begin
        rsum  = {1'b0, r_r} + {1'b0, RTAB[r_seg.n]};
        carry = rsum >= {1'b0, r_seg.n};
        n_r   = carry ? NW'(rsum - {1'b0, r_seg.n}) : rsum[NW-1:0];
        n_t   = r_t + QTAB[r_seg.n] + TW'(carry);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (en) begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (is_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (load) begin
                r_seg <= i_q_rec;
                r_s   <= '0;
                r_t   <= '0;
                r_r   <= '0;
            end else if (r_busy && !is_last) begin
                r_s <= r_s + 1'b1;
                r_t <= n_t;
                r_r <= n_r;
            end
        end
    end

    // stage 1: h1 = d3*t + d2*2^F
    assign tm0 = $signed({1'b0, r_t});
    assign m1x = r_seg.d3x * tm0;
    assign m1y = r_seg.d3y * tm0;

    // stage 2: h2 = h1*t + d1*2^2F
    assign tm1 = $signed({1'b0, r_t1});
    assign m2x = r_h1x * tm1;
    assign m2y = r_h1y * tm1;

    // stage 3: (h2*t + p0*2^3F + half) >> 3F
    assign tm2   = $signed({1'b0, r_t2});
    assign m3x   = r_h2x * tm2;
    assign m3y   = r_h2y * tm2;
    assign sum3x = m3x + (H3W'(r_p0x2) <<< (3 * FRAC_BITS))
                 + (H3W'(1) <<< (3 * FRAC_BITS - 1));
    assign sum3y = m3y + (H3W'(r_p0y2) <<< (3 * FRAC_BITS))
                 + (H3W'(1) <<< (3 * FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h1x      <= m1x + (H1W'(r_seg.d2x) <<< FRAC_BITS);
            r_h1y      <= m1y + (H1W'(r_seg.d2y) <<< FRAC_BITS);
            r_d1x      <= r_seg.d1x;
            r_d1y      <= r_seg.d1y;
            r_p0x1     <= r_seg.p0x;
            r_p0y1     <= r_seg.p0y;
            r_t1       <= r_t;
            r_m1.red   <= r_seg.red;
            r_m1.green <= r_seg.green;
            r_m1.blue  <= r_seg.blue;
            r_m1.blank <= r_seg.first && (r_s == '0);
            r_m1.last  <= is_last;

            r_h2x  <= m2x + (H2W'(r_d1x) <<< (2 * FRAC_BITS));
            r_h2y  <= m2y + (H2W'(r_d1y) <<< (2 * FRAC_BITS));
            r_p0x2 <= r_p0x1;
            r_p0y2 <= r_p0y1;
            r_t2   <= r_t1;
            r_m2   <= r_m1;

            r_pt.point_x    <= sum3x[3*FRAC_BITS+cbps_pkg::COORD_W-1:3*FRAC_BITS];
            r_pt.point_y    <= sum3y[3*FRAC_BITS+cbps_pkg::COORD_W-1:3*FRAC_BITS];
            r_pt.red        <= r_m2.red;
            r_pt.green      <= r_m2.green;
            r_pt.blue       <= r_m2.blue;
            r_pt.blank_jump <= r_m2.blank;
            r_pt.last_point <= r_m2.last;
        end
    end

    assign o_pt.valid   = r_v3;
    assign o_pt.payload = r_pt;

    a_s_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_s <= r_seg.n)
        else $error("sample index past step count");

    a_t_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_s == '0) |-> r_t == '0)
        else $error("t not zero on first sample");

    a_t_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && is_last) |-> r_t == ONE_T)
        else $error("t not one on final sample");

    a_last_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_pt.last_point) |-> !r_pt.blank_jump)
        else $error("final point flagged as blank jump");

endmodule

`default_nettype wire

>>> design/cubic_bezier_point_sampler_top.sv
// Cubic Bezier point sampler: one segment in, n+1 points out, n = samples (0 counts as 1).
// Path to the first point: front register, queue, sequencer load, stage 1, stage 2, output stage.
// Throughput: one point per cycle while the output is not stalled, set by the back-end
// sequencer issuing one t value per cycle; output stalls freeze the back end.
// Reset: synchronous active-low i_rst_n; clears handshake state, samples=10.
// Depends on cbps_pkg, cbps_if, cbps_front, cbps_queue, cbps_back.
`default_nettype none

module cubic_bezier_point_sampler_top #(
    parameter int FRAC_BITS = cbps_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [cbps_pkg::CFG_W-1:0]  i_cfg_wdata,
    cbps_seg_if.sink                         i_seg,
    cbps_pt_if.source                        o_pt
);

    // samples register; the user must write it only while the datapath is idle; the block does not enforce this
    logic [cbps_pkg::CFG_W-1:0] r_samples;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples <= cbps_pkg::SAMPLES_RST;
        end else if (i_cfg_we) begin
            r_samples <= i_cfg_wdata;
        end
    end

    // front -> queue
    logic               f_valid;
    cbps_pkg::t_seg_rec f_rec;
    logic               f_ready;

    // queue -> back
    logic               q_valid;
    cbps_pkg::t_seg_rec q_rec;
    logic               q_pop;

    // Front: registers each segment transfer and precomputes the power-basis
    // coefficients so the back end only runs Horner steps.
    cbps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_samples (r_samples),
        .i_seg     (i_seg),
        .o_valid   (f_valid),
        .o_rec     (f_rec),
        .i_ready   (f_ready)
    );

    // Short queue lets the front take the next segment while the back end
    // is still emitting points for the current one.
    cbps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_rec   (f_rec),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .o_rec   (q_rec),
        .i_pop   (q_pop)
    );

    // Back: t sequencer plus multiply pipeline; the next segment is loaded
    // on the same cycle the last point of the current one is issued.
    cbps_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_rec   (q_rec),
        .o_q_pop   (q_pop),
        .o_pt      (o_pt)
    );

endmodule

`default_nettype wire
